>>> hw/rtl/spq_pkg.sv
// shared types and constants for the sorted priority queue
// no dependencies; imported by spq_ram users, spq_ctrl and the top level
`default_nettype none
package spq_pkg;

   localparam int SPQ_DEPTH_DEFAULT = 64;
   localparam int DATA_W  = 32;
   localparam int PRIO_W  = 8;
   localparam int COUNT_W = 7;
   localparam int ENTRY_W = DATA_W + PRIO_W;

   typedef enum logic [1:0] {
      REQ_PUSH  = 2'd0,
      REQ_POP   = 2'd1,
      REQ_SWAP  = 2'd2,
      REQ_CLEAR = 2'd3
   } spq_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } spq_status_type;

   typedef struct packed {
      logic [DATA_W-1:0]  data;
      logic [PRIO_W-1:0]  prio;
      spq_status_type     status;
      logic [COUNT_W-1:0] count;
   } spq_result_type;

endpackage
`default_nettype wire

>>> hw/rtl/spq_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module spq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> hw/rtl/spq_ctrl.sv
// sequencer for the sorted priority queue: entry ram, swap scratch ram,
// one compare/index unit stepped per entry; depends on spq_pkg and spq_ram
`default_nettype none
module spq_ctrl
   import spq_pkg::*;
#(
   parameter int DEPTH = SPQ_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_type,
   input  wire logic [DATA_W-1:0]  req_data,
   input  wire logic [PRIO_W-1:0]  req_prio,
   output logic                    res_valid,
   input  wire logic               res_take,
   output spq_result_type          res
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_P_RD, S_P_CHK, S_S_RD, S_S_WR, S_P_INS,
      S_O_RD, S_O_TAKE, S_O_SRD, S_O_SWR,
      S_H_RD, S_H_CHK, S_T_RD, S_T_CHK,
      S_C_RD, S_C_WR, S_B_RD, S_B_WR, S_FIN
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      occ_ff, occ_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      h_ff, h_in;
   logic [CW-1:0]      t_ff, t_in;
   logic [PRIO_W-1:0]  hi_ff, hi_in;
   logic [PRIO_W-1:0]  lo_ff, lo_in;
   logic [DATA_W-1:0]  dat_ff, dat_in;
   logic [PRIO_W-1:0]  pri_ff, pri_in;
   logic [DATA_W-1:0]  odat_ff, odat_in;
   logic [PRIO_W-1:0]  opri_ff, opri_in;
   spq_status_type     ost_ff, ost_in;

   logic               m_we, t_we;
   logic [CW-1:0]      m_waddr, m_raddr, t_waddr, t_raddr;
   logic [ENTRY_W-1:0] m_wdata, m_rdata, t_wdata, t_rdata;
   logic [PRIO_W-1:0]  m_rpri;
   logic [CW-1:0]      idx_inc, idx_dec, src_k;
   logic [PRIO_W-1:0]  src_pri, ref_pri;
   logic [CW+COUNT_W-1:0] cnt_wide;

   spq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_main (
      .clock(clock), .we(m_we), .waddr(m_waddr[AW-1:0]), .wdata(m_wdata),
      .raddr(m_raddr[AW-1:0]), .rdata(m_rdata)
   );

   spq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_scratch (
      .clock(clock), .we(t_we), .waddr(t_waddr[AW-1:0]), .wdata(t_wdata),
      .raddr(t_raddr[AW-1:0]), .rdata(t_rdata)
   );

   assign m_rpri  = m_rdata[ENTRY_W-1 -: PRIO_W];
   assign idx_inc = idx_ff + CW'(1);
   assign idx_dec = idx_ff - CW'(1);

   // source entry and new priority for output slot idx of a swap
   always_comb begin
      if (idx_ff < t_ff) begin
         src_k   = occ_ff - t_ff + idx_ff;
         src_pri = hi_ff;
      end else if (idx_ff < occ_ff - h_ff) begin
         src_k   = h_ff + idx_ff - t_ff;
         src_pri = m_rpri;
      end else begin
         src_k   = idx_ff - (occ_ff - h_ff);
         src_pri = lo_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      occ_in   = occ_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      h_in     = h_ff;
      t_in     = t_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      dat_in   = dat_ff;
      pri_in   = pri_ff;
      odat_in  = odat_ff;
      opri_in  = opri_ff;
      ost_in   = ost_ff;
      ref_pri  = hi_ff;
      m_we     = 1'b0;
      m_waddr  = idx_ff;
      m_wdata  = m_rdata;
      m_raddr  = idx_ff;
      t_we     = 1'b0;
      t_waddr  = idx_ff;
      t_wdata  = {src_pri, m_rdata[DATA_W-1:0]};
      t_raddr  = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dat_in  = req_data;
               pri_in  = req_prio;
               odat_in = '0;
               opri_in = '0;
               ost_in  = ST_OK;
               idx_in  = '0;
               case (spq_op_type'(req_type))
                  REQ_PUSH: begin
                     if (occ_ff >= CW'(DEPTH)) begin
                        ost_in   = ST_FULL;
                        state_in = S_FIN;
                     end else if (occ_ff == '0) begin
                        pos_in   = '0;
                        state_in = S_P_INS;
                     end else begin
                        state_in = S_P_RD;
                     end
                  end
                  REQ_POP: begin
                     if (occ_ff == '0) begin
                        ost_in   = ST_EMPTY;
                        state_in = S_FIN;
                     end else begin
                        state_in = S_O_RD;
                     end
                  end
                  REQ_SWAP: begin
                     state_in = (occ_ff == '0) ? S_FIN : S_H_RD;
                  end
                  default: begin
                     occ_in   = '0;
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_P_RD: state_in = S_P_CHK;
         S_P_CHK: begin
            if (m_rpri > pri_ff && idx_inc != occ_ff) begin
               idx_in   = idx_inc;
               state_in = S_P_RD;
            end else begin
               pos_in   = (m_rpri > pri_ff) ? occ_ff : idx_ff;
               idx_in   = occ_ff;
               state_in = (m_rpri > pri_ff) ? S_P_INS : S_S_RD;
            end
         end
         S_S_RD: begin
            m_raddr  = idx_dec;
            state_in = S_S_WR;
         end
         S_S_WR: begin
            m_we     = 1'b1;
            idx_in   = idx_dec;
            state_in = (idx_dec > pos_ff) ? S_S_RD : S_P_INS;
         end
         S_P_INS: begin
            m_we     = 1'b1;
            m_waddr  = pos_ff;
            m_wdata  = {pri_ff, dat_ff};
            occ_in   = occ_ff + CW'(1);
            state_in = S_FIN;
         end
         S_O_RD: begin
            m_raddr  = '0;
            state_in = S_O_TAKE;
         end
         S_O_TAKE: begin
            odat_in = m_rdata[DATA_W-1:0];
            opri_in = m_rpri;
            idx_in  = CW'(1);
            if (occ_ff == CW'(1)) begin
               occ_in   = '0;
               state_in = S_FIN;
            end else begin
               state_in = S_O_SRD;
            end
         end
         S_O_SRD: state_in = S_O_SWR;
         S_O_SWR: begin
            m_we    = 1'b1;
            m_waddr = idx_dec;
            idx_in  = idx_inc;
            if (idx_inc == occ_ff) begin
               occ_in   = occ_ff - CW'(1);
               state_in = S_FIN;
            end else begin
               state_in = S_O_SRD;
            end
         end
         S_H_RD: state_in = S_H_CHK;
         S_H_CHK: begin
            ref_pri = (idx_ff == '0) ? m_rpri : hi_ff;
            hi_in   = ref_pri;
            if (m_rpri == ref_pri) begin
               idx_in   = idx_inc;
               // whole queue at one priority: nothing to swap
               state_in = (idx_inc == occ_ff) ? S_FIN : S_H_RD;
            end else begin
               h_in     = idx_ff;
               idx_in   = '0;
               state_in = S_T_RD;
            end
         end
         S_T_RD: begin
            m_raddr  = occ_ff - CW'(1) - idx_ff;
            state_in = S_T_CHK;
         end
         S_T_CHK: begin
            ref_pri = (idx_ff == '0) ? m_rpri : lo_ff;
            lo_in   = ref_pri;
            if (m_rpri == ref_pri) begin
               idx_in   = idx_inc;
               state_in = S_T_RD;
            end else begin
               t_in     = idx_ff;
               idx_in   = '0;
               state_in = S_C_RD;
            end
         end
         S_C_RD: begin
            m_raddr  = src_k;
            state_in = S_C_WR;
         end
         S_C_WR: begin
            t_we = 1'b1;
            if (idx_inc == occ_ff) begin
               idx_in   = '0;
               state_in = S_B_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = S_C_RD;
            end
         end
         S_B_RD: state_in = S_B_WR;
         S_B_WR: begin
            m_we     = 1'b1;
            m_wdata  = t_rdata;
            idx_in   = idx_inc;
            state_in = (idx_inc == occ_ff) ? S_FIN : S_B_RD;
         end
         S_FIN: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
      end
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      h_ff    <= h_in;
      t_ff    <= t_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      dat_ff  <= dat_in;
      pri_ff  <= pri_in;
      odat_ff <= odat_in;
      opri_ff <= opri_in;
      ost_ff  <= ost_in;
   end

   assign cnt_wide   = {{COUNT_W{1'b0}}, occ_ff};
   assign req_ready  = (state_ff == S_IDLE);
   assign res_valid  = (state_ff == S_FIN);
   assign res.data   = odat_ff;
   assign res.prio   = opri_ff;
   assign res.status = ost_ff;
   assign res.count  = cnt_wide[COUNT_W-1:0];

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(DEPTH))
      else $error("occupancy above depth");

   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_P_INS |-> occ_ff < CW'(DEPTH))
      else $error("insert into full queue");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_type == REQ_CLEAR) |=> occ_ff == '0)
      else $error("clear left entries");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_O_TAKE && occ_ff == CW'(1)) |=> occ_ff == '0)
      else $error("last pop did not empty queue");

endmodule
`default_nettype wire

>>> hw/rtl/sorted_priority_queue.sv
// top level of the sorted priority queue: sequencer plus result register
// depends on spq_pkg and spq_ctrl
//
// bounded priority queue of DEPTH entries held in ram sorted by falling
// priority; equal priorities leave newest first. one request gives exactly
// one response. requests are taken one at a time: req_ready is high only
// while the sequencer is idle. a push scans for its slot, then shifts the
// entries below it down; a pop shifts every remaining entry up; a swap of
// extremes finds the head and tail groups, builds the reordered queue in
// the scratch ram and copies it back; clear and rejected requests touch
// no ram. the pace is set by the single registered-read port of the entry
// ram, stepped one entry at a time. a finished response waits in an output
// register, so the next request can start before it is taken.
`default_nettype none
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH = SPQ_DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_type,
   input  wire logic signed [DATA_W-1:0]  req_item_data,
   input  wire logic [PRIO_W-1:0]         req_item_priority,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [DATA_W-1:0]       rsp_out_data,
   output logic [PRIO_W-1:0]              rsp_out_priority,
   output logic [1:0]                     rsp_status,
   output logic [COUNT_W-1:0]             rsp_entry_count
);

   logic           res_valid;
   logic           res_take;
   spq_result_type res;
   logic           rsp_valid_ff, rsp_valid_in;
   spq_result_type rsp_ff, rsp_in;

   spq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .req_data  (req_item_data),
      .req_prio  (req_item_priority),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res)
   );

   // result register is free when empty or being emptied this cycle
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_data     = rsp_ff.data;
   assign rsp_out_priority = rsp_ff.prio;
   assign rsp_status       = rsp_ff.status;
   assign rsp_entry_count  = rsp_ff.count;

   // a response is never overwritten while still pending
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !res_take)
      else $error("pending response overwritten");

   // sequencer never takes a request while a result is waiting inside it
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !req_ready)
      else $error("ready while result pending");

   a_load: assert property (@(posedge clock) disable iff (reset)
      res_take |=> rsp_valid_ff)
      else $error("response not loaded");

endmodule
`default_nettype wire
